@@ rtl/tvfs_pkg.sv @@
`default_nettype none

package tvfs_pkg;

   // Operation codes carried in the kind field.
   localparam logic [2:0] KIND_READ        = 3'd0;
   localparam logic [2:0] KIND_WRITE       = 3'd1;
   localparam logic [2:0] KIND_STAGE_ADD   = 3'd2;
   localparam logic [2:0] KIND_STAGE_DEL   = 3'd3;
   localparam logic [2:0] KIND_QUERY       = 3'd4;
   localparam logic [2:0] KIND_APPLY       = 3'd5;
   localparam logic [2:0] KIND_CLEAR       = 3'd6;

   // Three-valued truth codes.
   localparam logic [1:0] TRUTH_UNKNOWN    = 2'd0;
   localparam logic [1:0] TRUTH_TRUE       = 2'd1;
   localparam logic [1:0] TRUTH_FALSE      = 2'd2;

   localparam logic [11:0] MAX_FACT_RESET  = 12'd4095;

   typedef struct packed {
      logic [2:0]  kind;
      logic [11:0] fact_index;
      logic [1:0]  truth_in;
   } fs_req_type;

   typedef struct packed {
      logic [1:0] truth_out;
      logic       is_staged;
      logic       index_error;
   } fs_rsp_type;

   // One memory word holds everything known about a fact.
   typedef struct packed {
      logic known;
      logic value;
      logic pend_add;
      logic pend_del;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{known: 1'b1, value: 1'b0,
                                         pend_add: 1'b0, pend_del: 1'b0};

endpackage

`default_nettype wire

@@ rtl/three_valued_fact_store_core.sv @@
`default_nettype none

// Channel   | Ports                                  | Direction | Transaction when
// ----------+----------------------------------------+-----------+----------------------------
// request   | start, busy, req_payload               | in        | start high and busy low
// response  | rsp_strobe, rsp_payload                | out       | rsp_strobe high (one cycle)
// csr       | csr_valid, csr_ready, csr_data         | in        | csr_valid and csr_ready high
//
// Read, write, stage and query transactions read the fact's memory word when accepted, then
// modify and write it back in the execute state. The response appears the cycle after that.
// Apply and clear sweep the whole memory, one entry a cycle, through the sweep and flush states;
// the single read and single write port of the memory set this rate.
// After reset a clearing pass writes every entry to known false with nothing staged; busy
// stays high throughout it. Register writes are taken at any time.
// The receiver cannot stall, so every response is delivered on its strobe cycle.
module three_valued_fact_store_core #(
   parameter int FACT_COUNT = 4096
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire tvfs_pkg::fs_req_type req_payload,
   output logic                     rsp_strobe,
   output tvfs_pkg::fs_rsp_type     rsp_payload,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [11:0]              csr_data
);
   import tvfs_pkg::*;

   localparam int AW = $clog2(FACT_COUNT);
   localparam int IW = (AW > 12) ? AW : 12;
   localparam logic [AW-1:0] LAST_ADDR = AW'(FACT_COUNT - 1);

   // Controller states: clearing pass, idle, single-entry execute, sweep and final write.
   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] sw_addr_ff, sw_addr_in;
   logic        rdv_ff, rdv_in;
   logic        sweep_apply_ff, sweep_apply_in;
   logic [11:0] max_fact_ff, max_fact_in;

   // Operation held between the read and the write-back cycle.
   logic [2:0]    op_kind_ff, op_kind_in;
   logic [1:0]    op_truth_ff, op_truth_in;
   logic          op_err_ff, op_err_in;
   logic [AW-1:0] op_addr_ff, op_addr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   fs_rsp_type  rsp_payload_ff, rsp_payload_in;

   // Fact memory.
   entry_type   mem [FACT_COUNT];
   entry_type   mem_rd_ff;
   logic [AW-1:0] mem_ra, mem_wa;
   entry_type   mem_wd;
   logic        mem_we;

   logic          accept;
   logic [IW-1:0] idx_wide;
   logic [AW-1:0] req_addr;
   logic          req_bad_index;
   logic          req_bad_query;
   entry_type     exec_word;
   entry_type     sweep_word;
   fs_rsp_type    exec_rsp;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign idx_wide = IW'(req_payload.fact_index);
   assign req_addr = idx_wide[AW-1:0];
   assign req_bad_index = (req_payload.fact_index > max_fact_ff) ||
                          (32'(req_payload.fact_index) >= 32'(FACT_COUNT));
   assign req_bad_query = (req_payload.kind == KIND_QUERY) &&
                          (req_payload.truth_in != TRUTH_TRUE) &&
                          (req_payload.truth_in != TRUTH_FALSE);

   // Modification of one entry for a single-fact operation.
   always_comb begin
      exec_word = mem_rd_ff;
      exec_rsp  = '0;
      unique case (op_kind_ff)
         KIND_READ: begin
            if (!op_err_ff && mem_rd_ff.known) begin
               exec_rsp.truth_out = mem_rd_ff.value ? TRUTH_TRUE : TRUTH_FALSE;
            end
         end
         KIND_WRITE: begin
            unique case (op_truth_ff)
               TRUTH_TRUE: begin
                  exec_word.known = 1'b1;
                  exec_word.value = 1'b1;
               end
               TRUTH_FALSE: begin
                  exec_word.known = 1'b1;
                  exec_word.value = 1'b0;
               end
               TRUTH_UNKNOWN: begin
                  exec_word.known = 1'b0;
               end
               default: begin
               end
            endcase
         end
         KIND_STAGE_ADD: exec_word.pend_add = 1'b1;
         KIND_STAGE_DEL: exec_word.pend_del = 1'b1;
         KIND_QUERY: begin
            if (!op_err_ff) begin
               exec_rsp.is_staged = (op_truth_ff == TRUTH_TRUE) ? mem_rd_ff.pend_add
                                                                : mem_rd_ff.pend_del;
            end
         end
         default: begin
         end
      endcase
      exec_rsp.index_error = op_err_ff;
   end

   // Sweep modification: on apply, additions first and deletions override; pending marks are always dropped.
   always_comb begin
      sweep_word = mem_rd_ff;
      if (sweep_apply_ff) begin
         if (mem_rd_ff.pend_add) begin
            sweep_word.known = 1'b1;
            sweep_word.value = 1'b1;
         end
         if (mem_rd_ff.pend_del) begin
            sweep_word.known = 1'b1;
            sweep_word.value = 1'b0;
         end
      end
      sweep_word.pend_add = 1'b0;
      sweep_word.pend_del = 1'b0;
   end

   // Memory port selection.
   always_comb begin
      mem_ra = (state_ff == ST_IDLE) ? req_addr : cnt_ff;
      mem_we = 1'b0;
      mem_wa = sw_addr_ff;
      mem_wd = sweep_word;
      unique case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = ENTRY_RESET;
         end
         ST_EXEC: begin
            mem_we = !op_err_ff;
            mem_wa = op_addr_ff;
            mem_wd = exec_word;
         end
         ST_SWEEP: mem_we = rdv_ff;
         ST_FLUSH: mem_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sw_addr_in     = sw_addr_ff;
      rdv_in         = 1'b0;
      sweep_apply_in = sweep_apply_ff;
      op_kind_in     = op_kind_ff;
      op_truth_in    = op_truth_ff;
      op_err_in      = op_err_ff;
      op_addr_in     = op_addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      max_fact_in    = (csr_valid && csr_ready) ? csr_data : max_fact_ff;

      unique case (state_ff)
         ST_INIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_kind_in  = req_payload.kind;
               op_truth_in = req_payload.truth_in;
               op_addr_in  = req_addr;
               op_err_in   = ((req_payload.kind <= KIND_QUERY) && req_bad_index) ||
                             req_bad_query;
               if ((req_payload.kind == KIND_APPLY) || (req_payload.kind == KIND_CLEAR)) begin
                  sweep_apply_in = (req_payload.kind == KIND_APPLY);
                  cnt_in         = '0;
                  state_in       = ST_SWEEP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = exec_rsp;
            state_in       = ST_IDLE;
         end
         ST_SWEEP: begin
            rdv_in     = 1'b1;
            sw_addr_in = cnt_ff;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '0;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_fact_ff  <= MAX_FACT_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         max_fact_ff  <= max_fact_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_addr_ff     <= sw_addr_in;
      sweep_apply_ff <= sweep_apply_in;
      op_kind_ff     <= op_kind_in;
      op_truth_ff    <= op_truth_in;
      op_err_ff      <= op_err_in;
      op_addr_ff     <= op_addr_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // An accepted transaction always leaves the idle state on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not make the core busy");

   // Each transaction returns to idle before the next can start, so responses never come back to back.
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two responses in consecutive cycles");

   // A response is only produced from the write-back or final sweep cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_EXEC) || ($past(state_ff) == ST_FLUSH))
      else $error("response strobe without a completing operation");

   // An erroneous transaction never reports a truth value or a staged mark.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.index_error) |->
         ((rsp_payload.truth_out == TRUTH_UNKNOWN) && !rsp_payload.is_staged))
      else $error("error response carries data");

   // The sweep write stage only runs inside a sweep.
   a_sweep_write: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (state_ff == ST_SWEEP) || (state_ff == ST_FLUSH))
      else $error("sweep write outside a sweep");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import tvfs_pkg::*;

   localparam int FACT_COUNT = 4096;

   // The package names no code for kind 7 or for truth value 3; both are legal inputs.
   localparam logic [2:0] KIND_NOP       = 3'd7;
   localparam logic [1:0] TRUTH_RESERVED = 2'd3;

   // Longest time that a drain may go without progress: a full sweep, the gap before it
   // and some margin.
   localparam int DRAIN_LIMIT = 4 * FACT_COUNT + 1000;

   // An accepted operation together with the response that it must produce.
   typedef struct {
      fs_req_type op;
      fs_rsp_type rsp;
   } answer_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   logic       busy;
   fs_req_type req_payload = '0;
   logic       rsp_strobe;
   fs_rsp_type rsp_payload;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [11:0] csr_data   = '0;

   three_valued_fact_store_core #(
      .FACT_COUNT(FACT_COUNT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The run is cut off well beyond the slowest legal run, which is dominated by the
   // apply and clear sweeps over the whole store.
   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Predicted store contents. Each fact has a known bit, a value bit and two pending marks,
   // held here exactly as the block is meant to hold them, plus the current max_fact.
   // ---------------------------------------------------------------------------------------
   bit          known_bit   [FACT_COUNT];
   bit          value_bit   [FACT_COUNT];
   bit          staged_add  [FACT_COUNT];
   bit          staged_del  [FACT_COUNT];
   logic [11:0] fact_limit;

   // Queues between the stimulus, the driver and the checker.
   fs_req_type  queued_ops[$];
   answer_type  awaited_answers[$];

   int ops_queued     = 0;
   int ops_accepted   = 0;
   int mismatch_count = 0;
   int failures       = 0;
   int gap_left       = 0;
   bit idle_on        = 1'b1;
   int idle_odds      = 8;

   // Figures for the closing summary.
   int n_reads = 0, n_writes = 0, n_staged = 0, n_queries = 0, n_hits = 0;
   int n_applies = 0, n_clears = 0, n_errors = 0, n_nops = 0, n_settings = 0;

   function automatic void reset_fact_model();
      for (int i = 0; i < FACT_COUNT; i++) begin
         known_bit[i]  = 1'b1;
         value_bit[i]  = 1'b0;
         staged_add[i] = 1'b0;
         staged_del[i] = 1'b0;
      end
      fact_limit = MAX_FACT_RESET;
   endfunction

   // Carries out one operation on the predicted store and returns the response that the
   // block owes for it. Apply and clear ignore max_fact and sweep the whole store.
   function automatic fs_rsp_type fact_store_step(input fs_req_type op);
      fs_rsp_type  r;
      logic [11:0] idx;
      r   = '0;
      idx = op.fact_index;
      if (op.kind <= KIND_QUERY && (idx > fact_limit || int'(idx) >= FACT_COUNT)) begin
         r.index_error = 1'b1;
      end else begin
         case (op.kind)
            KIND_READ: begin
               if (!known_bit[idx])
                  r.truth_out = TRUTH_UNKNOWN;
               else
                  r.truth_out = value_bit[idx] ? TRUTH_TRUE : TRUTH_FALSE;
            end
            KIND_WRITE: begin
               // Writing unknown only drops the known bit; the reserved code does nothing.
               if (op.truth_in == TRUTH_TRUE) begin
                  known_bit[idx] = 1'b1;
                  value_bit[idx] = 1'b1;
               end else if (op.truth_in == TRUTH_FALSE) begin
                  known_bit[idx] = 1'b1;
                  value_bit[idx] = 1'b0;
               end else if (op.truth_in == TRUTH_UNKNOWN) begin
                  known_bit[idx] = 1'b0;
               end
            end
            KIND_STAGE_ADD: staged_add[idx] = 1'b1;
            KIND_STAGE_DEL: staged_del[idx] = 1'b1;
            KIND_QUERY: begin
               if (op.truth_in == TRUTH_TRUE)
                  r.is_staged = staged_add[idx];
               else if (op.truth_in == TRUTH_FALSE)
                  r.is_staged = staged_del[idx];
               else
                  r.index_error = 1'b1;
            end
            KIND_APPLY: begin
               // Additions first, then deletions, so a deletion wins over an addition.
               for (int i = 0; i < FACT_COUNT; i++) begin
                  if (staged_add[i]) begin
                     known_bit[i] = 1'b1;
                     value_bit[i] = 1'b1;
                  end
                  if (staged_del[i]) begin
                     known_bit[i] = 1'b1;
                     value_bit[i] = 1'b0;
                  end
                  staged_add[i] = 1'b0;
                  staged_del[i] = 1'b0;
               end
            end
            KIND_CLEAR: begin
               for (int i = 0; i < FACT_COUNT; i++) begin
                  staged_add[i] = 1'b0;
                  staged_del[i] = 1'b0;
               end
            end
            default: ;
         endcase
      end

      case (op.kind)
         KIND_READ:                      n_reads++;
         KIND_WRITE:                     n_writes++;
         KIND_STAGE_ADD, KIND_STAGE_DEL: n_staged++;
         KIND_QUERY:                     n_queries++;
         KIND_APPLY:                     n_applies++;
         KIND_CLEAR:                     n_clears++;
         default:                        n_nops++;
      endcase
      if (r.index_error) n_errors++;
      if (r.is_staged) n_hits++;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver. A request transaction completes at an edge where start is high and busy low;
   // the predictor runs at that very edge, so its state always follows the order in which
   // the block takes operations. After each transaction, or while start is low, the driver
   // either offers the next queued operation or inserts an idle burst.
   // start is assigned once per edge so that it can stay high across back-to-back items.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : driver_proc
      answer_type entry;
      logic       offer;
      if (reset) begin
         start    <= 1'b0;
         gap_left =  0;
      end else begin
         if (start && !busy) begin
            entry.op  = req_payload;
            entry.rsp = fact_store_step(req_payload);
            awaited_answers = {awaited_answers, entry};
            ops_accepted++;
         end
         if (!start || !busy) begin
            offer = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_ops.size() != 0) begin
               if (idle_on && $urandom_range(1, idle_odds) == 1) begin
                  gap_left = $urandom_range(0, 12);
               end else begin
                  req_payload <= queued_ops.pop_front();
                  offer       =  1'b1;
               end
            end
            start <= offer;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Checker. Responses cannot be held off, so every strobe cycle is one response
   // transaction, compared field by field with the oldest outstanding prediction.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : checker_proc
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("[%0t] response with none outstanding: truth %0d staged %0b error %0b",
                        $realtime, rsp_payload.truth_out, rsp_payload.is_staged,
                        rsp_payload.index_error);
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_payload.truth_out !== want.rsp.truth_out ||
                rsp_payload.is_staged !== want.rsp.is_staged ||
                rsp_payload.index_error !== want.rsp.index_error) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"[%0t] kind %0d fact %0d truth_in %0d: expected truth %0d ",
                            "staged %0b error %0b, got truth %0d staged %0b error %0b"},
                           $realtime, want.op.kind, want.op.fact_index, want.op.truth_in,
                           want.rsp.truth_out, want.rsp.is_staged, want.rsp.index_error,
                           rsp_payload.truth_out, rsp_payload.is_staged,
                           rsp_payload.index_error);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   task automatic queue_op(input logic [2:0] kind, input logic [11:0] idx,
                           input logic [1:0] tv);
      fs_req_type op;
      op.kind       = kind;
      op.fact_index = idx;
      op.truth_in   = tv;
      queued_ops = {queued_ops, op};
      ops_queued++;
   endtask

   // Mostly a small set of low facts so that staging, queries and reads meet each other,
   // with the edges around max_fact and the top of the index range mixed in.
   function automatic logic [11:0] pick_index();
      int sel;
      int v;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         v = $urandom_range(0, 15);
      end else if (sel < 7) begin
         v = int'(fact_limit) + $urandom_range(0, 4) - 2;
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
      end else if (sel == 7) begin
         v = 4095 - $urandom_range(0, 3);
      end else begin
         v = $urandom_range(0, 4095);
      end
      return 12'(v);
   endfunction

   function automatic logic [1:0] pick_truth();
      if ($urandom_range(0, 4) != 0)
         return $urandom_range(0, 1) ? TRUTH_TRUE : TRUTH_FALSE;
      return $urandom_range(0, 1) ? TRUTH_UNKNOWN : TRUTH_RESERVED;
   endfunction

   // A well-formed update round: stage a few facts, ask about them, sometimes commit or drop
   // the staging, then read them back.
   task automatic queue_update_round();
      logic [11:0] facts [4];
      int          n;
      int          ending;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) facts[i] = pick_index();
      if ($urandom_range(0, 3) == 0)
         queue_op(KIND_WRITE, facts[0], pick_truth());
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0, 1: queue_op(KIND_STAGE_ADD, facts[i], pick_truth());
            2, 3: queue_op(KIND_STAGE_DEL, facts[i], pick_truth());
            default: begin
               queue_op(KIND_STAGE_ADD, facts[i], pick_truth());
               queue_op(KIND_STAGE_DEL, facts[i], pick_truth());
            end
         endcase
      end
      for (int i = 0; i < n; i++) queue_op(KIND_QUERY, facts[i], pick_truth());
      ending = $urandom_range(0, 9);
      if (ending < 3)
         queue_op(KIND_APPLY, 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
      else if (ending == 3)
         queue_op(KIND_CLEAR, 12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)));
      for (int i = 0; i < n; i++) queue_op(KIND_READ, facts[i], pick_truth());
   endtask

   // A single operation with loosely drawn fields; sweeps and no-ops are kept uncommon.
   task automatic queue_loose_op();
      int          k;
      logic [2:0]  kind;
      logic [11:0] idx;
      k = $urandom_range(0, 19);
      if (k < 15)       kind = 3'(k / 3);
      else if (k == 15) kind = KIND_APPLY;
      else if (k == 16) kind = KIND_CLEAR;
      else              kind = KIND_NOP;
      idx = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : pick_index();
      queue_op(kind, idx, 2'($urandom_range(0, 3)));
   endtask

   task automatic queue_random_phase(input int count);
      int first;
      first = ops_queued;
      while (ops_queued - first < count) begin
         if ($urandom_range(0, 9) < 7)
            queue_update_round();
         else
            queue_loose_op();
      end
   endtask

   // Covers reads of the reset state, every kind of write, deletion winning over addition,
   // queries before and after apply, clear, the reserved codes and both ends of the index.
   task automatic queue_directed();
      queue_op(KIND_READ,      12'd0,    TRUTH_UNKNOWN);
      queue_op(KIND_READ,      12'd4095, TRUTH_RESERVED);
      queue_op(KIND_WRITE,     12'd0,    TRUTH_TRUE);
      queue_op(KIND_WRITE,     12'd4095, TRUTH_UNKNOWN);
      queue_op(KIND_WRITE,     12'd5,    TRUTH_RESERVED);
      queue_op(KIND_READ,      12'd0,    TRUTH_TRUE);
      queue_op(KIND_READ,      12'd4095, TRUTH_FALSE);
      queue_op(KIND_READ,      12'd5,    TRUTH_TRUE);
      queue_op(KIND_STAGE_ADD, 12'd0,    TRUTH_TRUE);
      queue_op(KIND_STAGE_DEL, 12'd0,    TRUTH_FALSE);
      queue_op(KIND_STAGE_ADD, 12'd4095, TRUTH_RESERVED);
      queue_op(KIND_QUERY,     12'd0,    TRUTH_TRUE);
      queue_op(KIND_QUERY,     12'd0,    TRUTH_FALSE);
      queue_op(KIND_QUERY,     12'd0,    TRUTH_UNKNOWN);
      queue_op(KIND_QUERY,     12'd4095, TRUTH_RESERVED);
      queue_op(KIND_APPLY,     12'd4095, TRUTH_RESERVED);
      queue_op(KIND_READ,      12'd0,    TRUTH_UNKNOWN);
      queue_op(KIND_READ,      12'd4095, TRUTH_UNKNOWN);
      queue_op(KIND_QUERY,     12'd4095, TRUTH_TRUE);
      queue_op(KIND_STAGE_ADD, 12'd9,    TRUTH_TRUE);
      queue_op(KIND_CLEAR,     12'd0,    TRUTH_UNKNOWN);
      queue_op(KIND_QUERY,     12'd9,    TRUTH_TRUE);
      queue_op(KIND_NOP,       12'hfff,  TRUTH_RESERVED);
      queue_op(KIND_WRITE,     12'd4095, TRUTH_FALSE);
      queue_op(KIND_READ,      12'd4095, TRUTH_UNKNOWN);
   endtask

   // Writes max_fact through the register channel; only ever called with nothing in flight.
   task automatic write_max_fact(input logic [11:0] limit);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      fact_limit =  limit;
      n_settings++;
   endtask

   // Holds the sender off until every queued operation has been taken and answered, then
   // lets the block settle. The wait gives up only when DRAIN_LIMIT is reached with neither
   // an acceptance nor a response seen since the last progress.
   task automatic wait_drained();
      int waited;
      int seen_accepted;
      int seen_left;
      waited        = 0;
      seen_accepted = ops_accepted;
      seen_left     = awaited_answers.size();
      while ((ops_accepted != ops_queued || awaited_answers.size() != 0) &&
             waited < DRAIN_LIMIT) begin
         @(posedge clock);
         if (ops_accepted != seen_accepted || awaited_answers.size() != seen_left) begin
            seen_accepted = ops_accepted;
            seen_left     = awaited_answers.size();
            waited        = 0;
         end else begin
            waited++;
         end
      end
      if (waited >= DRAIN_LIMIT) begin
         failures++;
         $display("[%0t] %0d responses never arrived", $realtime, awaited_answers.size());
      end
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence. Reset is held at the start and released once; the block then runs its
   // clearing pass with busy high, which the driver simply waits out. Each phase sets a new
   // max_fact, queues its operations and drains completely before the next register write,
   // which also keeps the sender paused during it. The final phase runs without idling.
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus_proc
      logic [11:0] mid_limit;
      reset_fact_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_max_fact(12'd4095);
      queue_directed();
      wait_drained();

      write_max_fact(12'd0);
      idle_odds = 3;
      queue_random_phase(150);
      wait_drained();

      mid_limit = 12'($urandom_range(100, 3000));
      write_max_fact(mid_limit);
      idle_odds = 10;
      queue_random_phase(250);
      wait_drained();

      write_max_fact(12'd9);
      idle_odds = 5;
      queue_random_phase(200);
      wait_drained();

      write_max_fact(12'd4095);
      idle_on = 1'b0;
      queue_random_phase(300);
      wait_drained();

      failures += mismatch_count;
      $display("Ran %0d operations over %0d max_fact settings: %0d reads, %0d writes, %0d stagings",
               ops_accepted, n_settings, n_reads, n_writes, n_staged);
      $display("%0d queries (%0d staged hits), %0d applies, %0d clears, %0d index errors, %0d no-ops",
               n_queries, n_hits, n_applies, n_clears, n_errors, n_nops);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/tvfs_pkg.sv
rtl/three_valued_fact_store_core.sv
tb/tb.sv
